### sv/ftdt_pkg.sv
// ----------------------------------------------------------------------------
// ftdt_pkg: shared types and constants of the float to decimal text block
// Character codes, emit kinds and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package ftdt_pkg;

	localparam int MAX_FRAC_DIGITS = 9;
	localparam int BCD_DIGITS      = 10;
	localparam int IPART_W         = 31;
	localparam int FRAC_W          = 54;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// what the datapath places in the output register
	localparam logic [2:0] K_MINUS = 3'd0;
	localparam logic [2:0] K_INT   = 3'd1;
	localparam logic [2:0] K_DOT   = 3'd2;
	localparam logic [2:0] K_FRAC  = 3'd3;
	localparam logic [2:0] K_ERR   = 3'd4;

	typedef struct packed {
		logic       load;
		logic       shift;
		logic       emit;
		logic [2:0] kind;
		logic [3:0] dig_idx;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic       is_err;
		logic       is_neg;
		logic [3:0] lead;
		logic       out_free;
	} stat_t;

endpackage

### sv/float_to_decimal_text.sv
// ----------------------------------------------------------------------------
// float_to_decimal_text: single-precision bit pattern to ASCII decimal text
// Emits '-', integer digits, '.', truncated fraction digits, one per transfer, or an error item.
// ----------------------------------------------------------------------------
// Sequence: an accepted number runs through the binary-to-BCD shifter, one bit
// per cycle, then the sign state, which emits a leading '-', then the digit
// states; an error item skips the shifter. Characters follow at one per cycle
// while the output is not stalled. A new number is accepted only once the last
// character of the previous one has been emitted.
// Reset (arst_n low): sequencer idle, output empty, frac_digits back to 3.
module float_to_decimal_text (
	input  logic        clk,
	input  logic        arst_n,
	// digit count register, written when cfg_we is high
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	// input stream: [31:0] value_bits
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// output stream: [7:0] char_out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	// last_char
	output logic        m_tlast,
	// [0] range_error
	output logic        m_tuser
);
	import ftdt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: accept, convert, then advance one character per transfer
	ftdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: hold the decoded number and the output register
	ftdt_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value_bits (s_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

### sv/ftdt_datapath.sv
// ----------------------------------------------------------------------------
// ftdt_datapath: decode, binary to BCD shifter, fraction scaler, output reg
// Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module ftdt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         value_bits,
	input  ftdt_pkg::cmd_t      cmd,
	output ftdt_pkg::stat_t     stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser
);
	import ftdt_pkg::*;

	logic [IPART_W-1:0]      ipart_q;
	logic [BCD_DIGITS-1:0][3:0] bcd_q;
	logic [FRAC_W-1:0]       frac_q;
	logic                    err_q;
	logic                    neg_q;

	// decode
	logic [7:0]        expo, expo_e;
	logic [23:0]       mant24;
	logic [7:0]        fs;
	logic [2:0]        ish;
	logic [IPART_W-1:0] ipart_d;
	logic [FRAC_W-1:0] fnum, frac_d;
	logic [5:0]        fsh;
	logic [30:0]       wide_i;

	always_comb begin
		expo   = value_bits[30:23];
		expo_e = (expo == 8'd0) ? 8'd1 : expo;
		mant24 = {(expo != 8'd0), value_bits[22:0]};
		ish    = 3'(expo_e - 8'd150);
		fs     = 8'd150 - expo_e;
		fsh    = 6'(7'd54 - 7'(fs));
		wide_i = 31'(mant24) << ish;
		ipart_d = '0;
		fnum    = '0;
		frac_d  = '0;
		if (expo_e >= 8'd150) begin
			ipart_d = wide_i;
		end else if (fs >= 8'd24) begin
			fnum = FRAC_W'(mant24);
		end else begin
			ipart_d = IPART_W'(mant24 >> fs[4:0]);
			fnum    = FRAC_W'(mant24 & 24'((25'd1 << fs[4:0]) - 25'd1));
		end
		if (fs < 8'd54 && expo_e < 8'd150)
			frac_d = fnum << fsh;
	end

	// one BCD step: add 3 to digits of five or more, then shift
	logic [BCD_DIGITS-1:0][3:0] bcd_adj;
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++)
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
	end

	logic [BCD_DIGITS*4:0] bcd_sh;
	assign bcd_sh = {bcd_adj, ipart_q[IPART_W-1]};

	// fraction times ten: digit falls out of the top
	logic [FRAC_W+3:0] frac_x10;
	assign frac_x10 = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ipart_q <= ipart_d;
			bcd_q   <= '0;
			frac_q  <= frac_d;
		end else begin
			if (cmd.shift) begin
				bcd_q   <= bcd_sh[BCD_DIGITS*4-1:0];
				ipart_q <= {ipart_q[IPART_W-2:0], 1'b0};
			end
			if (cmd.emit && cmd.kind == K_FRAC)
				frac_q <= frac_x10[FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
			neg_q <= 1'b0;
		end else if (cmd.load) begin
			err_q <= (expo >= 8'd158);
			neg_q <= value_bits[31] && (value_bits[30:0] != 31'd0);
		end
	end

	logic [3:0] lead;
	always_comb begin
		lead = '0;
		for (int i = 0; i < BCD_DIGITS; i++)
			if (bcd_q[i] != 4'd0)
				lead = 4'(i);
	end

	logic [7:0] ch;
	always_comb begin
		unique case (cmd.kind)
			K_MINUS: ch = CH_MINUS;
			K_INT:   ch = CH_ZERO + {4'd0, bcd_q[cmd.dig_idx]};
			K_DOT:   ch = CH_DOT;
			K_FRAC:  ch = CH_ZERO + {4'd0, frac_x10[FRAC_W+3:FRAC_W]};
			default: ch = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= ch;
			m_tlast <= cmd.last;
			m_tuser <= (cmd.kind == K_ERR);
		end
	end

	assign stat.is_err   = err_q;
	assign stat.is_neg   = neg_q;
	assign stat.lead     = lead;
	assign stat.out_free = !m_tvalid || m_tready;

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
		else $error("error item without last flag");

endmodule

### sv/ftdt_ctrl.sv
// ----------------------------------------------------------------------------
// ftdt_ctrl: sequencer of the float to decimal text block
// Holds the digit count register and steps through conversion and emission.
// ----------------------------------------------------------------------------
module ftdt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_data,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  ftdt_pkg::stat_t stat,
	output ftdt_pkg::cmd_t  cmd
);
	import ftdt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_SIGN = 3'd2;
	localparam logic [2:0] S_INT  = 3'd3;
	localparam logic [2:0] S_DOT  = 3'd4;
	localparam logic [2:0] S_FRAC = 3'd5;
	localparam logic [2:0] S_ERR  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [3:0] fd_q;
	logic [4:0] cnt_q, cnt_d;
	logic [3:0] dig_q, dig_d;
	logic [3:0] fcnt_q, fcnt_d;
	logic [3:0] fd;

	assign fd = (fd_q > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS) : fd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fd_q <= 4'd3;
		end else if (cfg_we) begin
			fd_q <= cfg_data;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		dig_d   = dig_q;
		fcnt_d  = fcnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				if (stat.is_err) begin
					state_d = S_ERR;
				end else begin
					cmd.shift = 1'b1;
					cnt_d     = cnt_q + 5'd1;
					if (cnt_q == 5'(IPART_W - 1))
						state_d = S_SIGN;
				end
			end
			S_SIGN: begin
				dig_d = stat.lead;
				if (!stat.is_neg) begin
					state_d = S_INT;
				end else if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = K_MINUS;
					state_d  = S_INT;
				end
			end
			S_INT: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = K_INT;
					cmd.dig_idx = dig_q;
					cmd.last    = (dig_q == 4'd0) && (fd == 4'd0);
					if (dig_q == 4'd0)
						state_d = (fd == 4'd0) ? S_IDLE : S_DOT;
					else
						dig_d = dig_q - 4'd1;
				end
			end
			S_DOT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = K_DOT;
					fcnt_d   = fd;
					state_d  = S_FRAC;
				end
			end
			S_FRAC: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = K_FRAC;
					cmd.last = (fcnt_q == 4'd1);
					fcnt_d   = fcnt_q - 4'd1;
					if (fcnt_q == 4'd1)
						state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = K_ERR;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			dig_q   <= '0;
			fcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dig_q   <= dig_d;
			fcnt_q  <= fcnt_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("emit into an occupied output register");

	a_frac_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRAC |-> fcnt_q != 4'd0 && fcnt_q <= 4'(MAX_FRAC_DIGITS))
		else $error("fraction count out of range");

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_CONV && cnt_q == 5'd0)
		else $error("accepted item did not start conversion");

endmodule
